[sv/fli_pkg.sv]
// Shared types, opcodes and arithmetic helpers for the Fourier LQG integrator.
package fli_pkg;
   localparam int COEF_WIDTH = 24;
   localparam int COEF_FRAC  = 20;

   typedef enum logic [2:0] {
      OP_FILTER   = 3'd0,
      OP_GAIN     = 3'd1,
      OP_DECAY    = 3'd2,
      OP_HIGHPASS = 3'd3,
      OP_CLEAR    = 3'd4
   } opcode_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [1:0]         layer;
      logic [11:0]        element;
      logic signed [23:0] value_re;
      logic signed [23:0] value_im;
   } req_word_type;

   typedef struct packed {
      logic [11:0]        out_element;
      logic signed [23:0] out_re;
      logic signed [23:0] out_im;
      logic               saturated;
   } rsp_word_type;

   // round half up of a Q20 product sum: add half, drop fraction
   function automatic logic signed [49:0] round_q20(input logic signed [69:0] v);
      logic signed [69:0] t;
      t = v + 70'sd524288;
      return t[69:20];
   endfunction
endpackage

[sv/fli_if.sv]
// Valid/ready channel carrying one word of payload.
interface fli_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/fli_cmac.sv]
// Registered complex multiply-accumulate of two complex products with Q20 rounding.
module fli_cmac import fli_pkg::*; #(
   parameter int DW = 24
) (
   input  logic                  clock,
   input  logic signed [DW-1:0]  xr, xi,
   input  logic signed [23:0]    gr, gi,
   input  logic signed [DW-1:0]  hr, hi,
   input  logic signed [23:0]    ar, ai,
   output logic signed [49:0]    res_re,
   output logic signed [49:0]    res_im
);
   logic signed [DW+23:0] p_ff [8];
   logic signed [DW+23:0] p_in [8];
   logic signed [69:0]    s_re, s_im;

   always_comb begin
      p_in[0] = xr * gr; p_in[1] = xi * gi;
      p_in[2] = hr * ar; p_in[3] = hi * ai;
      p_in[4] = xr * gi; p_in[5] = xi * gr;
      p_in[6] = hr * ai; p_in[7] = hi * ar;
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   always_comb begin
      s_re = 70'(p_ff[0]) - 70'(p_ff[1]) + 70'(p_ff[2]) - 70'(p_ff[3]);
      s_im = 70'(p_ff[4]) + 70'(p_ff[5]) + 70'(p_ff[6]) + 70'(p_ff[7]);
      res_re = round_q20(s_re);
      res_im = round_q20(s_im);
   end
endmodule

[sv/fourier_lqg_integrator.sv]
// Top level: per-element Fourier-domain LQG integrator with memory-held state.
// A filter word steps through read, multiply, sum and write for each layer, then out and fin;
// its result is registered in fin. One word is handled at a time; a filter word blocks input
// until its result is taken; coefficient writes finish in idle, and clears write each layer once.
// Reset (synchronous, high): clears control, then sweeps all NUM_LAYERS*NUM_ELEMENTS history
// entries, zeroing one per cycle, and the previous outputs; no word is accepted during the sweep.
module fourier_lqg_integrator import fli_pkg::*; #(
   parameter int NUM_LAYERS   = 4,
   parameter int NUM_ELEMENTS = 4096,
   parameter int DATA_WIDTH   = 24
) (
   input logic clock,
   input logic reset,
   fli_if.sink   req,
   fli_if.source rsp
);
   localparam int LW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
   localparam int EW = $clog2(NUM_ELEMENTS);
   localparam int DEPTH = NUM_LAYERS * NUM_ELEMENTS;
   localparam int AW = $clog2(DEPTH);
   localparam logic signed [49:0] DMAX = 50'sd1 <<< (DATA_WIDTH - 1);

   typedef enum logic [7:0] {
      S_SWEEP = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_READ  = 8'b0000_0100,
      S_MUL   = 8'b0000_1000,
      S_ACC   = 8'b0001_0000,
      S_WRITE = 8'b0010_0000,
      S_OUT   = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   // memories: complex words packed as {im, re}
   logic [2*DATA_WIDTH-1:0] hist_mem [DEPTH];
   logic [2*DATA_WIDTH-1:0] prev_mem [NUM_ELEMENTS];
   logic [47:0]             gain_mem [DEPTH];
   logic [47:0]             decay_mem [DEPTH];
   logic [47:0]             hp_mem   [NUM_ELEMENTS];

   state_type state_ff, state_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [LW:0]  lay_ff, lay_in;
   logic [2:0]   op_ff;
   logic [EW-1:0] elem_ff;
   logic signed [DATA_WIDTH-1:0] xr_ff, xi_ff;
   logic signed [DATA_WIDTH+LW+1:0] sum_re_ff, sum_im_ff, sum_re_in, sum_im_in;
   logic clip_ff, clip_in;
   logic [2*DATA_WIDTH-1:0] h_rd_ff, p_rd_ff;
   logic [47:0] g_rd_ff, a_rd_ff, hp_rd_ff;
   logic signed [DATA_WIDTH-1:0] hnew_re_ff, hnew_im_ff, hnew_re_in, hnew_im_in;
   logic rsp_valid_ff;
   logic [EW-1:0] rsp_elem_ff;
   logic signed [DATA_WIDTH-1:0] rsp_re_ff, rsp_im_ff;
   logic rsp_sat_ff;

   logic [AW-1:0] addr;
   logic signed [DATA_WIDTH-1:0] mr, mi, nr, ni;
   logic signed [23:0] cr, ci, dr, di;
   logic signed [49:0] res_re, res_im;
   logic signed [49:0] out_re_w, out_im_w;
   logic signed [DATA_WIDTH-1:0] o_re, o_im;
   logic o_clip;
   logic accept, elem_ok;

   assign addr = AW'(lay_ff[LW-1:0]) * AW'(NUM_ELEMENTS) + AW'(elem_ff);

   // saturate to data width
   function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [49:0] v,
                                                          output logic c);
      c = 1'b0;
      if (v > DMAX - 50'sd1) begin
         c = 1'b1; return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
      if (v < -DMAX) begin
         c = 1'b1; return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req.valid && req.ready;
   assign elem_ok   = 32'(req.payload.element) < NUM_ELEMENTS;

   // stage in multiply operands: layer update, or high-pass product
   always_comb begin
      if (state_ff == S_OUT || state_ff == S_FIN) begin
         mr = '0; mi = '0; cr = '0; ci = '0;
         nr = p_rd_ff[DATA_WIDTH-1:0]; ni = p_rd_ff[2*DATA_WIDTH-1:DATA_WIDTH];
         dr = hp_rd_ff[23:0]; di = hp_rd_ff[47:24];
      end else begin
         mr = xr_ff; mi = xi_ff;
         cr = g_rd_ff[23:0]; ci = g_rd_ff[47:24];
         nr = h_rd_ff[DATA_WIDTH-1:0]; ni = h_rd_ff[2*DATA_WIDTH-1:DATA_WIDTH];
         dr = a_rd_ff[23:0]; di = a_rd_ff[47:24];
      end
   end

   fli_cmac #(.DW(DATA_WIDTH)) u_cmac (
      .clock(clock), .xr(mr), .xi(mi), .gr(cr), .gi(ci),
      .hr(nr), .hi(ni), .ar(dr), .ai(di), .res_re(res_re), .res_im(res_im)
   );

   always_comb begin
      logic c1, c2;
      hnew_re_in = sat(res_re, c1);
      hnew_im_in = sat(res_im, c2);
      out_re_w = 50'(sum_re_ff) - res_re;
      out_im_w = 50'(sum_im_ff) - res_im;
      o_re = sat(out_re_w, c1);
      o_im = sat(out_im_w, c2);
      o_clip = c1 | c2;
   end

   always_comb begin
      logic c1, c2;
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      lay_in    = lay_ff;
      sum_re_in = sum_re_ff;
      sum_im_in = sum_im_ff;
      clip_in   = clip_ff;
      c1 = 1'b0; c2 = 1'b0;
      unique case (state_ff)
         S_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (32'(sweep_ff) == DEPTH - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            lay_in = '0; sum_re_in = '0; sum_im_in = '0; clip_in = 1'b0;
            if (accept && elem_ok) begin
               if (req.payload.opcode == OP_FILTER) state_in = S_READ;
               else if (req.payload.opcode == OP_CLEAR) state_in = S_WRITE;
            end
         end
         S_READ:  state_in = S_MUL;
         S_MUL:   state_in = S_ACC;
         S_ACC: begin
            void'(sat(res_re, c1));
            void'(sat(res_im, c2));
            clip_in = clip_ff | c1 | c2;
            sum_re_in = sum_re_ff + (DATA_WIDTH+LW+2)'(hnew_re_in);
            sum_im_in = sum_im_ff + (DATA_WIDTH+LW+2)'(hnew_im_in);
            state_in = S_WRITE;
         end
         S_WRITE: begin
            lay_in = lay_ff + 1'b1;
            if (32'(lay_ff) == NUM_LAYERS - 1)
               state_in = (op_ff == OP_CLEAR) ? S_IDLE : S_OUT;
            else if (op_ff != OP_CLEAR) state_in = S_READ;
         end
         S_OUT:   state_in = S_FIN;
         S_FIN:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_FIN) rsp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      lay_ff    <= lay_in;
      sum_re_ff <= sum_re_in;
      sum_im_ff <= sum_im_in;
      clip_ff   <= clip_in;
      if (state_ff == S_ACC) begin
         hnew_re_ff <= hnew_re_in;
         hnew_im_ff <= hnew_im_in;
      end
      if (accept) begin
         op_ff   <= req.payload.opcode;
         elem_ff <= req.payload.element[EW-1:0];
         xr_ff   <= req.payload.value_re[DATA_WIDTH-1:0];
         xi_ff   <= req.payload.value_im[DATA_WIDTH-1:0];
      end
      if (state_ff == S_FIN) begin
         rsp_elem_ff <= elem_ff;
         rsp_re_ff   <= o_re;
         rsp_im_ff   <= o_im;
         rsp_sat_ff  <= clip_ff | o_clip;
      end
   end

   // memory ports: registered reads, write back in the write step
   always_ff @(posedge clock) begin
      h_rd_ff  <= hist_mem[addr];
      g_rd_ff  <= gain_mem[addr];
      a_rd_ff  <= decay_mem[addr];
      p_rd_ff  <= prev_mem[elem_ff];
      hp_rd_ff <= hp_mem[elem_ff];
      // one history entry per cycle; previous outputs wrap through the low bits
      if (state_ff == S_SWEEP) begin
         prev_mem[sweep_ff[EW-1:0]] <= '0;
         hist_mem[sweep_ff] <= '0;
      end
      if (state_ff == S_WRITE) begin
         if (op_ff == OP_CLEAR) begin
            hist_mem[addr] <= '0;
            prev_mem[elem_ff] <= '0;
         end else begin
            hist_mem[addr] <= {hnew_im_ff, hnew_re_ff};
         end
      end
      if (state_ff == S_FIN) prev_mem[elem_ff] <= {o_im, o_re};
      if (accept && elem_ok && 32'(req.payload.layer) < NUM_LAYERS) begin
         if (req.payload.opcode == OP_GAIN)
            gain_mem[AW'(req.payload.layer) * AW'(NUM_ELEMENTS)
                     + AW'(req.payload.element)] <=
               {req.payload.value_im, req.payload.value_re};
         if (req.payload.opcode == OP_DECAY)
            decay_mem[AW'(req.payload.layer) * AW'(NUM_ELEMENTS)
                      + AW'(req.payload.element)] <=
               {req.payload.value_im, req.payload.value_re};
      end
      if (accept && elem_ok && req.payload.opcode == OP_HIGHPASS)
         hp_mem[req.payload.element[EW-1:0]] <=
            {req.payload.value_im, req.payload.value_re};
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.payload.out_element = 12'(rsp_elem_ff);
   assign rsp.payload.out_re      = 24'(rsp_re_ff);
   assign rsp.payload.out_im      = 24'(rsp_im_ff);
   assign rsp.payload.saturated   = rsp_sat_ff;
endmodule

[bench/fli_tb_pkg.sv]
`timescale 1ns / 100ps
// Bench-side sizes and the opcodes the block ignores.
package fli_tb_pkg;
   localparam int NUM_LAYERS   = 4;
   localparam int NUM_ELEMENTS = 4096;

   // opcodes the block has no use for
   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
endpackage

[bench/fli_checker.sv]
`timescale 1ns / 100ps
// Checker: watches both channels, predicts filter results and compares them.
module fli_checker import fli_pkg::*, fli_tb_pkg::*; (
   input  logic clock,
   input  logic reset,
   fli_if       req_bus,
   fli_if       rsp_bus,
   output int   fail_count,
   output int   pending_count
);
   typedef struct {
      int re;
      int im;
   } cplx_type;

   cplx_type     gain_tab[int];
   cplx_type     decay_tab[int];
   cplx_type     hp_tab[int];
   cplx_type     hist_tab[int];
   cplx_type     prev_tab[int];
   rsp_word_type filtered_q[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic cplx_type fetch(ref cplx_type tab[int], input int idx);
      cplx_type z;
      z = '{0, 0};
      if (tab.exists(idx)) z = tab[idx];
      return z;
   endfunction

   function automatic longint round_frac(input longint v);
      return (v + 64'sd524288) >>> 20;
   endfunction

   function automatic int clip24(input longint v, inout bit clipped);
      if (v > 64'sd8388607) begin
         clipped = 1;
         return 8388607;
      end
      if (v < -64'sd8388608) begin
         clipped = 1;
         return -8388608;
      end
      return int'(v);
   endfunction

   // advance the filter state for one word; queue its result when it makes one
   task automatic filter_step(input req_word_type w);
      cplx_type     c, g, a, h, e, hp;
      longint       x, y, pr, pi, sum_re, sum_im, acc_re, acc_im;
      bit           clipped;
      int           idx, base;
      rsp_word_type r;
      clipped = 0;
      sum_re  = 0;
      sum_im  = 0;
      c.re    = int'(w.value_re);
      c.im    = int'(w.value_im);
      base    = int'(w.element);
      idx     = int'(w.layer) * NUM_ELEMENTS + base;
      case (w.opcode)
         OP_GAIN:     gain_tab[idx] = c;
         OP_DECAY:    decay_tab[idx] = c;
         OP_HIGHPASS: hp_tab[base] = c;
         OP_CLEAR: begin
            for (int l = 0; l < NUM_LAYERS; l++) hist_tab[l * NUM_ELEMENTS + base] = '{0, 0};
            prev_tab[base] = '{0, 0};
         end
         OP_FILTER: begin
            x = c.re;
            y = c.im;
            for (int l = 0; l < NUM_LAYERS; l++) begin
               idx = l * NUM_ELEMENTS + base;
               g = fetch(gain_tab, idx);
               a = fetch(decay_tab, idx);
               h = fetch(hist_tab, idx);
               acc_re = x * g.re - y * g.im + longint'(h.re) * a.re - longint'(h.im) * a.im;
               acc_im = x * g.im + y * g.re + longint'(h.re) * a.im + longint'(h.im) * a.re;
               h.re = clip24(round_frac(acc_re), clipped);
               h.im = clip24(round_frac(acc_im), clipped);
               hist_tab[idx] = h;
               sum_re += h.re;
               sum_im += h.im;
            end
            e  = fetch(prev_tab, base);
            hp = fetch(hp_tab, base);
            pr = longint'(e.re) * hp.re - longint'(e.im) * hp.im;
            pi = longint'(e.re) * hp.im + longint'(e.im) * hp.re;
            e.re = clip24(sum_re - round_frac(pr), clipped);
            e.im = clip24(sum_im - round_frac(pi), clipped);
            prev_tab[base] = e;
            r.out_element = w.element;
            r.out_re      = e.re[23:0];
            r.out_im      = e.im[23:0];
            r.saturated   = clipped;
            filtered_q.push_back(r);
         end
         default: ;
      endcase
   endtask

   // inputs only move at the rising edge, so a handshake seen here lands on the next one
   always @(negedge clock) begin
      rsp_word_type want, got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) filter_step(req_bus.payload);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            if (filtered_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word %p", $time, got);
            end else begin
               want = filtered_q.pop_front();
               if (got.out_element !== want.out_element) begin
                  fail_count++;
                  $display("%0t: out_element expected %0d got %0d", $time,
                           want.out_element, got.out_element);
               end
               if (got.out_re !== want.out_re) begin
                  fail_count++;
                  $display("%0t: out_re expected %0d got %0d", $time, want.out_re, got.out_re);
               end
               if (got.out_im !== want.out_im) begin
                  fail_count++;
                  $display("%0t: out_im expected %0d got %0d", $time, want.out_im, got.out_im);
               end
               if (got.saturated !== want.saturated) begin
                  fail_count++;
                  $display("%0t: saturated expected %0b got %0b", $time,
                           want.saturated, got.saturated);
               end
            end
         end
         pending_count = filtered_q.size();
      end
   end
endmodule

[bench/tb_fourier_lqg_integrator.sv]
`timescale 1ns / 100ps
// Testbench top: drives coefficient, filter, clear and spare-opcode words and gives the verdict.
module tb_fourier_lqg_integrator import fli_pkg::*, fli_tb_pkg::*;;

   localparam int WORD_TARGET = 1850;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   words_sent;
   int   cycle_count;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   primed[$];     // elements whose whole coefficient set has been written

   fli_if #(.payload_type(req_word_type)) req_bus ();
   fli_if #(.payload_type(rsp_word_type)) rsp_bus ();

   fourier_lqg_integrator u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   fli_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // stall the result side at the rate of the current phase
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fourier_lqg_integrator verification failed");
         $finish;
      end
   end

   // hold the word until the block takes it; ready is stable from the falling edge on
   task automatic push_word(input req_word_type w);
      logic took;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= w;
      do begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end while (!took);
      words_sent++;
   endtask

   function automatic req_word_type make_word(input logic [2:0] op, input int layer,
                                              input int elem, input int re, input int im);
      req_word_type w;
      w.opcode   = op;
      w.layer    = layer[1:0];
      w.element  = elem[11:0];
      w.value_re = re[23:0];
      w.value_im = im[23:0];
      return w;
   endfunction

   // sample or coefficient: mostly below one in Q4.20, some full range, some rails
   function automatic int pick_value();
      case ($urandom_range(7))
         0:       return -8388608;
         1:       return 8388607;
         2, 3:    return int'($urandom) >>> 8;
         default: return $urandom_range(2097151) - 1048576;
      endcase
   endfunction

   // write every gain, decay and the highpass of one element, then mark it usable
   task automatic prime_element(input int elem);
      for (int l = 0; l < NUM_LAYERS; l++) begin
         push_word(make_word(OP_GAIN, l, elem, pick_value(), pick_value()));
         push_word(make_word(OP_DECAY, l, elem, pick_value(), pick_value()));
      end
      push_word(make_word(OP_HIGHPASS, 0, elem, pick_value(), pick_value()));
      primed.push_back(elem);
   endtask

   task automatic random_word();
      int pick, elem;
      pick = $urandom_range(99);
      elem = primed[$urandom_range(primed.size() - 1)];
      if (pick < 6) begin
         prime_element($urandom_range(NUM_ELEMENTS - 1));
      end else if (pick < 72) begin
         push_word(make_word(OP_FILTER, $urandom_range(3), elem, pick_value(), pick_value()));
      end else if (pick < 80) begin
         push_word(make_word(3'($urandom_range(OP_HIGHPASS, OP_GAIN)), $urandom_range(3), elem,
                             pick_value(), pick_value()));
      end else if (pick < 85) begin
         push_word(make_word(OP_CLEAR, $urandom_range(3), $urandom_range(NUM_ELEMENTS - 1),
                             int'($urandom), int'($urandom)));
      end else if (pick < 90) begin
         // spare opcode on any element: no result, no state change
         push_word(make_word(3'($urandom_range(OP_SPARE_7, OP_SPARE_5)), $urandom_range(3),
                             $urandom_range(NUM_ELEMENTS - 1), int'($urandom), int'($urandom)));
      end else if (pick < 95) begin
         // stray coefficient write to any element; only primed ones are ever filtered
         push_word(make_word(OP_GAIN, $urandom_range(3), $urandom_range(NUM_ELEMENTS - 1),
                             int'($urandom), int'($urandom)));
      end else begin
         push_word(make_word(OP_CLEAR, 0, elem, 0, 0));
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.payload <= '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      words_sent      = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: rail coefficients on the lowest and highest element
      for (int l = 0; l < NUM_LAYERS; l++) begin
         push_word(make_word(OP_GAIN, l, 0, 8388607, -8388608));
         push_word(make_word(OP_DECAY, l, 0, 1048576, 0));
         push_word(make_word(OP_GAIN, l, 4095, 524288, 0));
         push_word(make_word(OP_DECAY, l, 4095, -8388608, 8388607));
      end
      push_word(make_word(OP_HIGHPASS, 0, 0, 8388607, 8388607));
      push_word(make_word(OP_HIGHPASS, 0, 4095, 0, -8388608));
      primed.push_back(0);
      primed.push_back(4095);
      // saturating samples, a zero sample, then clear and a spare opcode
      push_word(make_word(OP_FILTER, 0, 0, 8388607, -8388608));
      push_word(make_word(OP_FILTER, 0, 0, 0, 0));
      push_word(make_word(OP_FILTER, 0, 4095, -8388608, 8388607));
      push_word(make_word(OP_FILTER, 0, 4095, 1, -1));
      push_word(make_word(OP_CLEAR, 0, 4095, 0, 0));
      push_word(make_word(OP_FILTER, 0, 4095, 8388607, 8388607));
      push_word(make_word(OP_SPARE_5, 3, 0, -1, -1));
      push_word(make_word(OP_FILTER, 0, 0, -1, 1));

      // random: four idle phases, the last mixes both sides
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 34 : 0;
         recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 34 : 0;
         while (words_sent < (ph + 1) * WORD_TARGET / 4) random_word();
      end
      req_bus.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("fourier_lqg_integrator verification clean");
      end else begin
         $display("fourier_lqg_integrator verification failed");
      end
      $finish;
   end
endmodule
